// ===== rtl/sial_pkg.sv =====
// Shared types and constants for the shift-insert array list.
`timescale 1ns / 1ps
package sial_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned OP_W = 3;
	localparam int unsigned POS_W = 9;
	localparam int unsigned LEN_W = 9;
	localparam int unsigned ST_W = 2;
	// wide enough for a count up to 4096
	localparam int unsigned IDX_W = 13;

	localparam logic [OP_W-1:0] OP_READ = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
	localparam logic [OP_W-1:0] OP_ERASE = 3'd4;
	localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic [POS_W-1:0] position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [LEN_W-1:0] length;
		logic [ST_W-1:0] status;
	} res_t;

	// Broadcast to every cell of the row.
	// ins: cell lo loads value, cells in (lo, hi] take the left neighbor.
	// ers: cells in [lo, hi) take the right neighbor.
	// rd:  cell lo drives its word onto the read tap.
	typedef struct packed {
		logic ins;
		logic ers;
		logic rd;
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		logic signed [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== rtl/sial_cell.sv =====
// One storage cell of the list row: holds a word, shifts with its neighbors.
`timescale 1ns / 1ps
module sial_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                              clk,
	input  sial_pkg::cell_ctl_t               ctl,
	input  logic signed [sial_pkg::DATA_W-1:0] left,
	input  logic signed [sial_pkg::DATA_W-1:0] right,
	output logic signed [sial_pkg::DATA_W-1:0] data,
	output logic signed [sial_pkg::DATA_W-1:0] tap
);
	import sial_pkg::*;

	localparam logic [IDX_W-1:0] IDX = IDX_W'(INDEX);

	logic signed [DATA_W-1:0] data_q;
	logic at_lo;

	assign at_lo = (IDX == ctl.lo);

	always_ff @(posedge clk) begin
		priority if (ctl.ins && at_lo) begin
			data_q <= ctl.value;
		end else if (ctl.ins && IDX > ctl.lo && IDX <= ctl.hi) begin
			data_q <= left;
		end else if (ctl.ers && IDX >= ctl.lo && IDX < ctl.hi) begin
			data_q <= right;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;
	assign tap = (ctl.rd && at_lo) ? data_q : '0;

endmodule

// ===== rtl/shift_insert_array_list_unit.sv =====
// Top level of the shift-insert array list: cell row, request decode, read tree.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH signed 32-bit words kept packed from position 0.
// One request is taken per clock (busy stays low) and its result comes out
// with done in request order, after the request, partial and result registers;
// the result is shown for one cycle only, so the receiver must take it then.
// The row of cells applies an insert, erase, append or remove to the whole
// list in the cycle after acceptance, so back-to-back requests always see the
// state left by the one before. The read word is collected by a two-level OR
// tree over 16-cell groups with a register after each level. Storage needs no
// clearing after reset.
module shift_insert_array_list_unit #(
	parameter int unsigned DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sial_pkg::req_t    req,
	output logic              done,
	output sial_pkg::res_t    res
);
	import sial_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned GRP = 16;
	localparam int unsigned NGRP = (DEPTH + GRP - 1) / GRP;

	// stage 1: request register, state update
	logic valid_s1;
	req_t req_s1;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] nxt_cnt;
	logic [ST_W-1:0] st;
	cell_ctl_t ctl;
	logic [IDX_W-1:0] n;
	logic [IDX_W-1:0] p;

	// stage 2: group partials of the read word
	logic valid_s2;
	logic [LEN_W-1:0] len_s2;
	logic [ST_W-1:0] st_s2;
	logic signed [DATA_W-1:0] part_s2 [NGRP];

	logic signed [DATA_W-1:0] cell_data [DEPTH];
	logic signed [DATA_W-1:0] cell_tap [DEPTH];
	logic signed [DATA_W-1:0] grp_or [NGRP];
	logic signed [DATA_W-1:0] rd_word;

	logic done_q;
	res_t res_q;

	// the pipeline never stalls
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign n = IDX_W'(cnt_q);
	assign p = IDX_W'(req_s1.position);

	always_comb begin
		nxt_cnt = cnt_q;
		st = ST_OK;
		ctl.ins = 1'b0;
		ctl.ers = 1'b0;
		ctl.rd = 1'b0;
		ctl.lo = p;
		ctl.hi = n;
		ctl.value = req_s1.value;
		if (valid_s1) begin
			unique case (req_s1.op)
				OP_READ: begin
					if (n == '0) begin
						st = ST_EMPTY;
					end else if (p >= n) begin
						st = ST_RANGE;
					end else begin
						ctl.rd = 1'b1;
					end
				end
				OP_APPEND: begin
					if (n >= IDX_W'(DEPTH)) begin
						st = ST_FULL;
					end else begin
						ctl.ins = 1'b1;
						ctl.lo = n;
						nxt_cnt = cnt_q + 1'b1;
					end
				end
				OP_REMOVE: begin
					if (n == '0) begin
						st = ST_EMPTY;
					end else begin
						nxt_cnt = cnt_q - 1'b1;
					end
				end
				OP_INSERT: begin
					if (n >= IDX_W'(DEPTH)) begin
						st = ST_FULL;
					end else if (p > n) begin
						st = ST_RANGE;
					end else begin
						ctl.ins = 1'b1;
						nxt_cnt = cnt_q + 1'b1;
					end
				end
				OP_ERASE: begin
					if (n == '0) begin
						st = ST_EMPTY;
					end else if (p >= n) begin
						st = ST_RANGE;
					end else begin
						// last live cell keeps a stale copy; it drops out of the list
						ctl.ers = 1'b1;
						ctl.hi = n - 1'b1;
						nxt_cnt = cnt_q - 1'b1;
					end
				end
				OP_CLEAR: begin
					nxt_cnt = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= nxt_cnt;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		sial_cell #(
			.INDEX(i)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.left (left_d),
			.right(right_d),
			.data (cell_data[i]),
			.tap  (cell_tap[i])
		);
	end

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_or[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					grp_or[g] = grp_or[g] | cell_tap[g * GRP + k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			len_s2 <= LEN_W'(nxt_cnt);
			st_s2 <= st;
			for (int g = 0; g < NGRP; g++) begin
				part_s2[g] <= grp_or[g];
			end
		end
	end

	always_comb begin
		rd_word = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_word = rd_word | part_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			res_q.read_value <= rd_word;
			res_q.length <= len_s2;
			res_q.status <= st_s2;
		end
	end

	assign done = done_q;
	assign res = res_q;

endmodule

// ===== rtl/sial_chk.sv =====
// Port-level checks for the shift-insert array list, bound to the top level.
`timescale 1ns / 1ps
module sial_chk #(
	parameter int unsigned DEPTH = 256
) (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input sial_pkg::req_t req,
	input logic           done,
	input sial_pkg::res_t res
);
	import sial_pkg::*;

	// every accepted request yields exactly one result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("accepted request produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3))
		else $error("result without a matching request");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.length <= LEN_W'(DEPTH))
		else $error("reported length exceeds depth");

	// a nonzero word can only come from a successful read
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.read_value != '0 |-> res.status == ST_OK)
		else $error("read word returned with an error status");

endmodule

bind shift_insert_array_list_unit sial_chk #(.DEPTH(DEPTH)) u_sial_chk (.*);

// ===== bench/shift_insert_array_list_checker.sv =====
// Checker for the list unit: tracks list contents, predicts each result, compares.
`timescale 1ns / 1ps
module shift_insert_array_list_checker #(
	parameter int unsigned DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  sial_pkg::req_t req,
	input  logic           done,
	input  sial_pkg::res_t res,
	output int             mismatches,
	output int             outstanding
);
	import sial_pkg::*;

	logic signed [DATA_W-1:0] words [DEPTH];
	int unsigned word_count = 0;
	res_t awaited_results [$];
	res_t oldest;
	int fault_count = 0;
	int pending = 0;

	assign mismatches = fault_count;
	assign outstanding = pending;

	// Applies one request to the list copy and returns the result it should produce.
	function automatic res_t apply_request(input req_t r);
		res_t out;
		out = '0;
		case (r.op)
		OP_READ: begin
			if (word_count == 0)
				out.status = ST_EMPTY;
			else if (r.position >= word_count)
				out.status = ST_RANGE;
			else
				out.read_value = words[r.position];
		end
		OP_APPEND: begin
			if (word_count >= DEPTH) begin
				out.status = ST_FULL;
			end else begin
				words[word_count] = r.value;
				word_count++;
			end
		end
		OP_REMOVE: begin
			if (word_count == 0)
				out.status = ST_EMPTY;
			else
				word_count--;
		end
		OP_INSERT: begin
			// full wins over a bad position
			if (word_count >= DEPTH) begin
				out.status = ST_FULL;
			end else if (r.position > word_count) begin
				out.status = ST_RANGE;
			end else begin
				for (int i = word_count; i > r.position; i--)
					words[i] = words[i - 1];
				words[r.position] = r.value;
				word_count++;
			end
		end
		OP_ERASE: begin
			if (word_count == 0) begin
				out.status = ST_EMPTY;
			end else if (r.position >= word_count) begin
				out.status = ST_RANGE;
			end else begin
				for (int i = r.position; i + 1 < word_count; i++)
					words[i] = words[i + 1];
				word_count--;
			end
		end
		OP_CLEAR: word_count = 0;
		default: ;
		endcase
		out.length = word_count[LEN_W-1:0];
		return out;
	endfunction

	// Appends one predicted result behind the ones already waiting.
	function automatic void queue_result(input res_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	task automatic compare_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
			fault_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count = 0;
			awaited_results.delete();
			pending = 0;
		end else begin
			if (done === 1'b1) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result: read_value %0d, length %0d, status %0d",
						$time, res.read_value, res.length, res.status);
					fault_count++;
				end else begin
					oldest = awaited_results.pop_front();
					compare_field("read_value", oldest.read_value, res.read_value);
					compare_field("length", oldest.length, res.length);
					compare_field("status", oldest.status, res.status);
				end
			end
			if (start && !busy)
				queue_result(apply_request(req));
			pending = awaited_results.size();
		end
	end

endmodule

// ===== bench/shift_insert_array_list_unit_test.sv =====
// Testbench top for the list unit: request stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module shift_insert_array_list_unit_test;
	import sial_pkg::*;

	localparam int unsigned LIST_DEPTH = 256;
	localparam int unsigned RANDOM_REQUESTS = 1800;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	res_t res;
	int mismatches;
	int outstanding;

	// length as the stimulus sees it, used to aim positions and steer growth
	int unsigned list_len = 0;
	int unsigned sent = 0;
	int unsigned fills = 0;
	int unsigned full_refusals = 0;
	int unsigned empty_refusals = 0;
	int unsigned stall_cycles = 0;
	bit no_gaps = 1'b0;

	shift_insert_array_list_unit #(
		.DEPTH(LIST_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res)
	);

	shift_insert_array_list_checker #(
		.DEPTH(LIST_DEPTH)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.res(res),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Ends the run if neither a request nor a result moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return '0;
		3: return '1;
		default: return $urandom();
		endcase
	endfunction

	// limit = number of legal positions; mostly legal, with edges and wild picks
	function automatic int unsigned pick_position(input int unsigned limit);
		int unsigned roll;
		roll = $urandom_range(99);
		if (limit == 0 || roll < 8)
			return $urandom_range(511);
		if (roll < 14)
			return limit;
		if (roll < 22)
			return 0;
		if (roll < 30)
			return limit - 1;
		return $urandom_range(limit - 1);
	endfunction

	// Holds one request until the unit takes it, then maybe leaves a gap.
	task automatic issue(input logic [OP_W-1:0] op, input int unsigned pos,
		input logic [DATA_W-1:0] val);
		req_t r;
		req_t noise;
		int unsigned len_before;
		r.op = op;
		r.position = pos[POS_W-1:0];
		r.value = val;
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		sent++;
		len_before = list_len;
		case (op)
		OP_READ: if (list_len == 0) empty_refusals++;
		OP_APPEND: begin
			if (list_len < LIST_DEPTH)
				list_len++;
			else
				full_refusals++;
		end
		OP_REMOVE: begin
			if (list_len > 0)
				list_len--;
			else
				empty_refusals++;
		end
		OP_INSERT: begin
			if (list_len >= LIST_DEPTH)
				full_refusals++;
			else if (pos <= list_len)
				list_len++;
		end
		OP_ERASE: begin
			if (list_len == 0)
				empty_refusals++;
			else if (pos < list_len)
				list_len--;
		end
		OP_CLEAR: list_len = 0;
		default: ;
		endcase
		if (list_len == LIST_DEPTH && len_before < LIST_DEPTH)
			fills++;
		@(negedge clk);
		if (!no_gaps && $urandom_range(99) < 15) begin
			noise.op = OP_W'($urandom());
			noise.position = POS_W'($urandom());
			noise.value = $urandom();
			start <= 1'b0;
			req <= noise;
			repeat ($urandom_range(2, 1)) @(negedge clk);
		end
	endtask

	initial begin
		int target;
		int linger;
		int unsigned seg_age;
		int unsigned roll;
		int unsigned grow_roll;
		bit grow;
		logic [OP_W-1:0] op;
		int unsigned pos;

		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty-list refusals, then a short list built from the edges
		issue(OP_READ, 0, '0);
		issue(OP_REMOVE, 0, '0);
		issue(OP_ERASE, 0, '0);
		issue(OP_INSERT, 1, 32'h1234_5678);
		issue(OP_INSERT, 0, 32'h7FFF_FFFF);
		issue(OP_APPEND, 511, 32'h8000_0000);
		issue(OP_APPEND, 0, 32'hFFFF_FFFF);
		issue(OP_INSERT, 1, 32'h0000_0000);
		issue(OP_INSERT, 4, 32'h5555_5555);	// insert at the length acts as append
		issue(OP_INSERT, 511, 32'hAAAA_AAAA);
		issue(OP_READ, 0, '1);
		issue(OP_READ, 4, '0);
		issue(OP_READ, 5, '0);
		issue(OP_READ, 511, '0);
		issue(OP_ERASE, 5, '0);
		issue(OP_ERASE, 0, '0);
		issue(OP_ERASE, 3, '0);
		issue(OP_READ, 1, '0);
		issue(OP_UNUSED_LO, 2, $urandom());
		issue(OP_UNUSED_HI, 511, $urandom());
		issue(OP_CLEAR, 0, '0);
		issue(OP_CLEAR, 511, '1);

		// segments steer the length toward a target, then linger around it
		target = LIST_DEPTH;
		linger = -1;
		seg_age = 0;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (linger < 0 && list_len == target)
				linger = $urandom_range(60, 15);
			if (linger == 0 || seg_age > 900) begin
				roll = $urandom_range(99);
				target = roll < 35 ? LIST_DEPTH : roll < 60 ? 0 : $urandom_range(LIST_DEPTH - 1, 1);
				linger = -1;
				seg_age = 0;
			end
			no_gaps = (n >= 700 && n < 1000);
			roll = $urandom_range(99);
			grow_roll = $urandom_range(99);
			if (list_len < target)
				grow = grow_roll < 80;
			else if (list_len > target)
				grow = grow_roll < 20;
			else
				grow = grow_roll < 50;
			if (roll < 3)
				op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
			else if (roll < 6 && target == 0)
				op = OP_CLEAR;
			else if (roll < 26)
				op = OP_READ;
			else if (grow)
				op = $urandom_range(1) ? OP_APPEND : OP_INSERT;
			else
				op = $urandom_range(1) ? OP_REMOVE : OP_ERASE;
			case (op)
			OP_READ, OP_ERASE: pos = pick_position(list_len);
			OP_INSERT: pos = pick_position(list_len + 1);
			default: pos = $urandom_range(511);
			endcase
			issue(op, pos, pick_value());
			if (linger > 0)
				linger--;
			seg_age++;
		end

		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d list requests; the list reached full depth %0d times.", sent, fills);
		$display("Refused at full depth: %0d; refused on an empty list: %0d.",
			full_refusals, empty_refusals);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
